FILE: rtl/fpec_pkg.sv
// ----------------------------------------------------------------------------
// fpec_pkg
// shared types and constants of the flash program/erase controller front end
// ----------------------------------------------------------------------------
package fpec_pkg;

    localparam int unsigned PAGE_BYTES = 1024;
    localparam int unsigned ROW_BYTES  = 512;

    localparam int unsigned ADDR_W = 29;
    localparam int unsigned SIZE_W = 30;
    localparam int unsigned SUM_W  = 31;
    localparam int unsigned WORD_W = 32;

    localparam int unsigned S_TDATA_W = 136;
    localparam int unsigned M_TDATA_W = 96;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] KEY_FIRST  = 32'haa996655;
    localparam logic [WORD_W-1:0] KEY_SECOND = 32'h556699aa;

    localparam logic [ADDR_W-1:0] PROG_BASE_RST = 29'h1d000000;
    localparam logic [ADDR_W-1:0] BOOT_BASE_RST = 29'h1fc00000;

    localparam logic [ADDR_W-1:0] ROW_MASK  = ADDR_W'(ROW_BYTES - 1);
    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

    typedef enum logic [1:0] {
        KEY_LOCKED = 2'd0,
        KEY_HALF   = 2'd1,
        KEY_OPEN   = 2'd2
    } t_key_step;

    typedef enum logic [3:0] {
        NVM_NOP   = 4'd0,
        NVM_WORD  = 4'd1,
        NVM_ROW   = 4'd3,
        NVM_ERASE = 4'd4
    } t_nvm_op;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_WORD  = 2'd1,
        ACT_ROW   = 2'd2,
        ACT_ERASE = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROG_BASE = 2'd0,
        CFG_PROG_SIZE = 2'd1,
        CFG_BOOT_BASE = 2'd2,
        CFG_BOOT_SIZE = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_KEY  = 1'b0,
        OP_CTRL = 1'b1
    } t_op;

endpackage

FILE: rtl/flash_program_erase_controller.sv
// ----------------------------------------------------------------------------
// flash_program_erase_controller
// unlock key sequencer and program/erase command decoder
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries register writes: tuser selects key (0) or control (1),
//   tdata holds the key word, control bits, op code, target, data and
//   source address. m_axis returns one result per transaction: the
//   WR output bit, the WRERR flag, the decoded command and the unlock status.
//   the cfg channel writes the region bases and sizes; it is always ready
//   and is meant to be used only while no transaction is in flight.
// throughput:
//   one transaction per cycle while m_axis_tready holds; a transaction is
//   captured in an input register, decoded and checked combinationally from
//   it, and its result is then registered in the output register.
// reset:
//   the key sequencer relocks, regions return to their default bases with
//   size zero, both pipeline registers are emptied.
// stall:
//   a stalled output holds its result; the input register still fills,
//   then s_axis tready drops until the output register is taken.
// ----------------------------------------------------------------------------
module flash_program_erase_controller
    import fpec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // key_value, wr_bit, wren_bit, nvm_op, target_addr, word_value, source_addr
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // wr_out, wrerr_set, region, flash_offset, data_out, source_phys, unlocked
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // action
    output logic [1:0]            m_axis_tuser,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [WORD_W-1:0]     i_cfg_data
);

    // configuration
    logic [ADDR_W-1:0] r_prog_base;
    logic [SIZE_W-1:0] r_prog_size;
    logic [ADDR_W-1:0] r_boot_base;
    logic [SIZE_W-1:0] r_boot_size;

    t_key_step r_key_step;
    t_key_step n_key_step;

    // input register
    logic                 r_s1_valid;
    logic                 r_s1_op;
    logic [WORD_W-1:0]    r_s1_key;
    logic                 r_s1_wr;
    logic                 r_s1_wren;
    logic [3:0]           r_s1_nvm_op;
    logic [WORD_W-1:0]    r_s1_addr;
    logic [WORD_W-1:0]    r_s1_data;
    logic [WORD_W-1:0]    r_s1_src;

    // output register
    logic                 r_out_valid;
    logic                 r_out_wr;
    logic                 r_out_err;
    t_action              r_out_action;
    logic                 r_out_region;
    logic [ADDR_W-1:0]    r_out_offset;
    logic [WORD_W-1:0]    r_out_data;
    logic [ADDR_W-1:0]    r_out_sphys;
    logic                 r_out_unlocked;

    logic                 n_wr;
    logic                 n_err;
    t_action              n_action;
    logic                 n_region;
    logic [ADDR_W-1:0]    n_offset;
    logic [WORD_W-1:0]    n_data;
    logic [ADDR_W-1:0]    n_sphys;

    logic                 advance;
    logic                 s_accept;

    logic [ADDR_W-1:0]    phys;
    logic [SUM_W-1:0]     prog_end;
    logic [SUM_W-1:0]     boot_end;
    logic                 in_prog;
    logic                 in_boot;
    logic                 hit;
    logic                 hit_region;
    logic [ADDR_W-1:0]    hit_off;
    logic [SIZE_W-1:0]    hit_size;
    logic [ADDR_W-1:0]    row_off;
    logic [ADDR_W-1:0]    erase_off;
    logic                 word_fits;
    logic                 row_fits;
    logic                 page_fits;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // region match
    assign phys     = r_s1_addr[ADDR_W-1:0];
    assign prog_end = SUM_W'(r_prog_base) + SUM_W'(r_prog_size);
    assign boot_end = SUM_W'(r_boot_base) + SUM_W'(r_boot_size);
    assign in_prog  = (r_prog_size != '0) && (phys >= r_prog_base)
                      && (SUM_W'(phys) < prog_end);
    assign in_boot  = (r_boot_size != '0) && (phys >= r_boot_base)
                      && (SUM_W'(phys) < boot_end);
    assign hit        = in_prog || in_boot;
    assign hit_region = !in_prog;
    assign hit_off    = in_prog ? (phys - r_prog_base) : (phys - r_boot_base);
    assign hit_size   = in_prog ? r_prog_size : r_boot_size;
    assign row_off    = hit_off & ~ROW_MASK;
    assign erase_off  = hit_off & ~PAGE_MASK;
    assign word_fits  = (SUM_W'(hit_off) + SUM_W'(4)) <= SUM_W'(hit_size);
    assign row_fits   = (SUM_W'(row_off) + SUM_W'(ROW_BYTES)) <= SUM_W'(hit_size);
    assign page_fits  = (SUM_W'(erase_off) + SUM_W'(PAGE_BYTES)) <= SUM_W'(hit_size);

    always_comb begin
        n_key_step = r_key_step;
        n_wr       = 1'b0;
        n_err      = 1'b0;
        n_action   = ACT_NONE;
        n_region   = 1'b0;
        n_offset   = '0;
        n_data     = '0;
        n_sphys    = '0;
        if (r_s1_op == OP_KEY) begin
            if (r_s1_key == KEY_FIRST && r_key_step == KEY_LOCKED) begin
                n_key_step = KEY_HALF;
            end else if (r_s1_key == KEY_SECOND && r_key_step == KEY_HALF) begin
                n_key_step = KEY_OPEN;
            end else begin
                n_key_step = KEY_LOCKED;
            end
        end else if (r_s1_wr) begin
            n_key_step = KEY_LOCKED;
            n_err      = 1'b1;
            if (r_key_step == KEY_OPEN && r_s1_wren) begin
                case (r_s1_nvm_op)
                    NVM_NOP: begin
                        n_err = 1'b0;
                    end
                    NVM_WORD: begin
                        if (r_s1_addr[1:0] == 2'b00 && hit && word_fits) begin
                            n_err    = 1'b0;
                            n_action = ACT_WORD;
                            n_region = hit_region;
                            n_offset = hit_off;
                            n_data   = r_s1_data;
                        end
                    end
                    NVM_ROW: begin
                        if (hit && row_fits) begin
                            n_err    = 1'b0;
                            n_action = ACT_ROW;
                            n_region = hit_region;
                            n_offset = row_off;
                            // kseg0, kseg1 and the default mask all keep the low 29 bits
                            n_sphys  = r_s1_src[ADDR_W-1:0];
                        end
                    end
                    NVM_ERASE: begin
                        if (hit && page_fits) begin
                            n_err    = 1'b0;
                            n_action = ACT_ERASE;
                            n_region = hit_region;
                            n_offset = erase_off;
                        end
                    end
                    default: begin
                        n_err = 1'b1;
                    end
                endcase
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_base <= PROG_BASE_RST;
            r_prog_size <= '0;
            r_boot_base <= BOOT_BASE_RST;
            r_boot_size <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_PROG_BASE: r_prog_base <= i_cfg_data[ADDR_W-1:0];
                CFG_PROG_SIZE: r_prog_size <= i_cfg_data[SIZE_W-1:0];
                CFG_BOOT_BASE: r_boot_base <= i_cfg_data[ADDR_W-1:0];
                CFG_BOOT_SIZE: r_boot_size <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_key_step  <= KEY_LOCKED;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_key_step <= n_key_step;
                end
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_op     <= s_axis_tuser;
            r_s1_key    <= s_axis_tdata[31:0];
            r_s1_wr     <= s_axis_tdata[32];
            r_s1_wren   <= s_axis_tdata[33];
            r_s1_nvm_op <= s_axis_tdata[37:34];
            r_s1_addr   <= s_axis_tdata[69:38];
            r_s1_data   <= s_axis_tdata[101:70];
            r_s1_src    <= s_axis_tdata[133:102];
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_wr       <= n_wr;
            r_out_err      <= n_err;
            r_out_action   <= n_action;
            r_out_region   <= n_region;
            r_out_offset   <= n_offset;
            r_out_data     <= n_data;
            r_out_sphys    <= n_sphys;
            r_out_unlocked <= (n_key_step == KEY_OPEN);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_action;
    assign m_axis_tdata  = {2'b00, r_out_unlocked, r_out_sphys, r_out_data,
                            r_out_offset, r_out_region, r_out_err, r_out_wr};

    // a control write with WR always relocks
    a_wr_relocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_s1_valid && r_s1_op == OP_CTRL && r_s1_wr
        |=> r_key_step == KEY_LOCKED)
        else $error("key sequencer not relocked after WR");

    // a command is never issued together with an error
    a_cmd_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_action != ACT_NONE |-> !r_out_err && !r_out_unlocked)
        else $error("command issued with error or still unlocked");

    // data word only travels with a word program
    a_data_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data != '0 |-> r_out_action == ACT_WORD)
        else $error("data word outside word program");

    // unlocked only follows a key write
    a_unlock_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_s1_valid && n_key_step == KEY_OPEN && r_key_step != KEY_OPEN
        |-> r_s1_op == OP_KEY)
        else $error("unlock without key write");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the flash program/erase controller front end:
// key and control register writes stream in with random gaps, a local
// model of the unlock sequencer and command decoder predicts each result
// not fixed by a directed row, and a scoreboard compares them field by field
// ----------------------------------------------------------------------------
module tb
    import fpec_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DIR_N          = 21;
    localparam logic [3:0]  NVM_BAD_LO     = 4'd2;
    localparam logic [3:0]  NVM_BAD_HI     = 4'd15;

    typedef struct {
        t_op         op;
        logic [31:0] key;
        logic        wr;
        logic        wren;
        logic [3:0]  nvm;
        logic [31:0] target;
        logic [31:0] data;
        logic [31:0] src;
    } t_req;

    typedef struct packed {
        logic        wr_out;
        logic        wrerr;
        t_action     action;
        logic        region;
        logic [28:0] offset;
        logic [31:0] data;
        logic [28:0] sphys;
        logic        unlocked;
    } t_result;

    typedef struct {
        logic        cfg_first;
        logic        unlock_first;
        t_op         op;
        logic [31:0] key;
        logic        wr;
        logic        wren;
        logic [3:0]  nvm;
        logic [31:0] target;
        logic [31:0] data;
        logic [31:0] src;
        logic        typed;
        logic        e_err;
        logic        e_unl;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    logic [28:0] rg_prog_base = PROG_BASE_RST;
    logic [29:0] rg_prog_size = '0;
    logic [28:0] rg_boot_base = BOOT_BASE_RST;
    logic [29:0] rg_boot_size = '0;
    t_key_step   key_state = KEY_LOCKED;

    t_result     cmd_q[$];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned idle_cycles = 0;
    int unsigned rx_hold = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    t_dir_row dir_tab[DIR_N] = '{
        '{0, 0, OP_KEY, 32'h0, 0, 0, NVM_NOP, 32'h0, 32'h0, 32'h0, 1, 0, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_WORD, 32'h1d000000, 32'h12345678, 32'h0, 1, 1, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_NOP, 32'h0, 32'h0, 32'h0, 1, 0, 0},
        '{1, 0, OP_KEY, KEY_FIRST, 0, 0, NVM_NOP, 32'h0, 32'h0, 32'h0, 1, 0, 0},
        '{0, 0, OP_KEY, KEY_SECOND, 0, 0, NVM_NOP, 32'h0, 32'h0, 32'h0, 1, 0, 1},
        '{0, 0, OP_CTRL, 32'h0, 0, 1, NVM_WORD, 32'h1d000010, 32'hdeadbeef, 32'h0, 1, 0, 1},
        '{0, 0, OP_CTRL, 32'h0, 1, 0, NVM_WORD, 32'h1d000010, 32'hdeadbeef, 32'h0, 1, 1, 0},
        '{0, 0, OP_KEY, KEY_SECOND, 0, 0, NVM_NOP, 32'h0, 32'h0, 32'h0, 1, 0, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_BAD_HI, 32'h1d000000, 32'h0, 32'h0, 1, 1, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_BAD_LO, 32'h1d000000, 32'h0, 32'h0, 1, 1, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_WORD, 32'h9d000102, 32'h1, 32'h0, 1, 1, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_WORD, 32'hfd000000, 32'hffffffff, 32'hffffffff,
          0, 0, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_WORD, 32'h1d03fffc, 32'h0, 32'h0, 0, 0, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_WORD, 32'h1d040000, 32'h5a5a5a5a, 32'h0, 1, 1, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_ROW, 32'hbfc02fff, 32'h0, 32'h80001234, 0, 0, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_ROW, 32'h1d0001ff, 32'h0, 32'hffffffff, 0, 0, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_ERASE, 32'h1fc02c00, 32'h0, 32'ha0ffffff, 0, 0, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_ERASE, 32'h1d03ffff, 32'h0, 32'h0, 0, 0, 0},
        '{0, 1, OP_CTRL, 32'h0, 1, 1, NVM_ERASE, 32'h1fc03000, 32'h0, 32'h0, 1, 1, 0},
        '{0, 0, OP_KEY, KEY_FIRST, 0, 0, NVM_NOP, 32'h0, 32'h0, 32'h0, 1, 0, 0},
        '{0, 0, OP_KEY, KEY_FIRST, 0, 0, NVM_NOP, 32'h0, 32'h0, 32'h0, 1, 0, 0}
    };

    // prog base/size, boot base/size for the fixed settings
    logic [31:0] region_tab[4][4] = '{
        '{32'h1d000000, 32'h00040000, 32'h1fc00000, 32'h00003000},
        '{32'h00000000, 32'h20000000, 32'h1fffffff, 32'h20000000},
        '{32'h1fffffff, 32'h00000001, 32'h00000000, 32'h00000400},
        '{32'h1ffff000, 32'h00000000, 32'h1ffffc00, 32'h20000000}
    };

    flash_program_erase_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // unlock sequencer and command decoder
    function automatic t_result decode_write(t_req r);
        t_result     res;
        logic [30:0] p;
        logic [30:0] off;
        logic [30:0] sz;
        logic        hit;
        logic        sel;
        logic        ok;
        res = '0;
        hit = 1'b1;
        sel = 1'b0;
        ok  = 1'b0;
        off = '0;
        sz  = '0;
        p   = {2'b00, r.target[28:0]};
        if (rg_prog_size != 0 && p >= {2'b00, rg_prog_base} &&
            p < {2'b00, rg_prog_base} + {1'b0, rg_prog_size}) begin
            off = p - {2'b00, rg_prog_base};
            sz  = {1'b0, rg_prog_size};
        end else if (rg_boot_size != 0 && p >= {2'b00, rg_boot_base} &&
                     p < {2'b00, rg_boot_base} + {1'b0, rg_boot_size}) begin
            sel = 1'b1;
            off = p - {2'b00, rg_boot_base};
            sz  = {1'b0, rg_boot_size};
        end else begin
            hit = 1'b0;
        end
        if (r.op == OP_KEY) begin
            if (r.key == KEY_FIRST && key_state == KEY_LOCKED)
                key_state = KEY_HALF;
            else if (r.key == KEY_SECOND && key_state == KEY_HALF)
                key_state = KEY_OPEN;
            else
                key_state = KEY_LOCKED;
        end else if (r.wr) begin
            if (key_state == KEY_OPEN && r.wren) begin
                case (r.nvm)
                    NVM_NOP: ok = 1'b1;
                    NVM_WORD: begin
                        if (r.target[1:0] == 2'b00 && hit && off + 31'd4 <= sz) begin
                            ok = 1'b1;
                            res.action = ACT_WORD;
                            res.data   = r.data;
                        end
                    end
                    NVM_ROW: begin
                        off = off & ~31'(ROW_BYTES - 1);
                        if (hit && off + 31'(ROW_BYTES) <= sz) begin
                            ok = 1'b1;
                            res.action = ACT_ROW;
                            // kseg0, kseg1 and unmapped space all reduce to the low bits
                            res.sphys  = r.src[28:0];
                        end
                    end
                    NVM_ERASE: begin
                        off = off & ~31'(PAGE_BYTES - 1);
                        if (hit && off + 31'(PAGE_BYTES) <= sz) begin
                            ok = 1'b1;
                            res.action = ACT_ERASE;
                        end
                    end
                    default: ok = 1'b0;
                endcase
            end
            if (ok && res.action != ACT_NONE) begin
                res.region = sel;
                res.offset = off[28:0];
            end
            key_state = KEY_LOCKED;
            res.wrerr = !ok;
        end
        res.unlocked = (key_state == KEY_OPEN);
        return res;
    endfunction

    function automatic t_req key_req(logic [31:0] value);
        t_req r;
        r = '{OP_KEY, value, 1'b0, 1'b0, NVM_NOP, 32'h0, 32'h0, 32'h0};
        return r;
    endfunction

    task automatic send_item(t_req r, bit typed = 1'b0, t_result fixed_res = '0);
        int unsigned gap;
        t_result     want;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {2'b00, r.src, r.data, r.target, r.nvm, r.wren, r.wr, r.key};
        do @(posedge i_clk); while (!s_axis_tready);
        want = decode_write(r);
        if (typed)
            want = fixed_res;
        cmd_q.push_back(want);
        items_sent++;
        gap = pick_gap(tx_calm);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (cmd_q.size() != 0);
    endtask

    task automatic write_regions(logic [31:0] vals[4]);
        drain();
        repeat (4) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= t_cfg_idx'(i);
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (t_cfg_idx'(i))
                CFG_PROG_BASE: rg_prog_base = vals[i][28:0];
                CFG_PROG_SIZE: rg_prog_size = vals[i][29:0];
                CFG_BOOT_BASE: rg_boot_base = vals[i][28:0];
                CFG_BOOT_SIZE: rg_boot_size = vals[i][29:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_target();
        logic [28:0] base;
        logic [29:0] size;
        logic [28:0] off;
        logic [31:0] t;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel >= 8)
            return $urandom;
        base = (sel < 4) ? rg_prog_base : rg_boot_base;
        size = (sel < 4) ? rg_prog_size : rg_boot_size;
        case ($urandom_range(0, 2))
            0: off = 29'($urandom_range(0, 2047));
            1: off = 29'(size) - 29'($urandom_range(1, 1100));
            default: off = (size != 0) ? 29'($urandom_range(0, size - 1)) : 29'($urandom);
        endcase
        t = {3'($urandom), base + off};
        if ($urandom_range(0, 3) != 0)
            t[1:0] = 2'b00;
        return t;
    endfunction

    function automatic logic [31:0] rand_source();
        case ($urandom_range(0, 2))
            0: return {3'b100, 29'($urandom)};
            1: return {3'b101, 29'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] rand_nvm();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return NVM_WORD;
        if (r < 55) return NVM_ROW;
        if (r < 80) return NVM_ERASE;
        if (r < 88) return NVM_NOP;
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic run_random(int unsigned n);
        int unsigned goal;
        int unsigned next_mode;
        int unsigned r;
        t_req        c;
        goal      = items_sent + n;
        next_mode = items_sent;
        while (items_sent < goal) begin
            if (items_sent >= next_mode) begin
                tx_calm   = ($urandom_range(0, 3) == 0);
                rx_calm   = ($urandom_range(0, 3) == 0);
                next_mode = items_sent + 50;
            end
            c = '{OP_CTRL, $urandom, 1'b1, 1'b1, rand_nvm(), rand_target(), $urandom,
                  rand_source()};
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_item(key_req(KEY_FIRST));
                send_item(key_req(KEY_SECOND));
                c.wren = ($urandom_range(0, 15) != 0);
                send_item(c);
            end else if (r < 78) begin
                send_item(key_req($urandom));
            end else if (r < 84) begin
                send_item(key_req(($urandom_range(0, 1) != 0) ? KEY_FIRST : KEY_SECOND));
            end else begin
                c.wr   = 1'($urandom_range(0, 1));
                c.wren = 1'($urandom_range(0, 1));
                c.nvm  = 4'($urandom_range(0, 15));
                send_item(c);
            end
            if ($urandom_range(0, 49) == 0)
                drain();
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            rx_hold <= pick_gap(rx_calm);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.wr_out   = m_axis_tdata[0];
            got.wrerr    = m_axis_tdata[1];
            got.region   = m_axis_tdata[2];
            got.offset   = m_axis_tdata[31:3];
            got.data     = m_axis_tdata[63:32];
            got.sphys    = m_axis_tdata[92:64];
            got.unlocked = m_axis_tdata[93];
            got.action   = t_action'(m_axis_tuser);
            if (cmd_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual %h/%h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                want = cmd_q.pop_front();
                check_field("wr_out", want.wr_out, got.wr_out);
                check_field("wrerr_set", want.wrerr, got.wrerr);
                check_field("action", want.action, got.action);
                check_field("region", want.region, got.region);
                check_field("flash_offset", want.offset, got.offset);
                check_field("data_out", want.data, got.data);
                check_field("source_phys", want.sphys, got.sphys);
                check_field("unlocked", want.unlocked, got.unlocked);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_req        r;
        t_result     tr;
        logic [31:0] vals[4];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].cfg_first) begin
                vals = region_tab[0];
                write_regions(vals);
            end
            if (dir_tab[i].unlock_first) begin
                send_item(key_req(KEY_FIRST));
                send_item(key_req(KEY_SECOND));
            end
            r = '{dir_tab[i].op, dir_tab[i].key, dir_tab[i].wr, dir_tab[i].wren,
                  dir_tab[i].nvm, dir_tab[i].target, dir_tab[i].data, dir_tab[i].src};
            tr = '{1'b0, dir_tab[i].e_err, ACT_NONE, 1'b0,
                   29'h0, 32'h0, 29'h0, dir_tab[i].e_unl};
            send_item(r, dir_tab[i].typed, tr);
        end
        run_random(140);

        for (int ph = 1; ph < 5; ph++) begin
            if (ph < 4) begin
                vals = region_tab[ph];
            end else begin
                vals[0] = {3'b000, 29'($urandom)};
                vals[1] = $urandom_range(0, 32'h8000);
                vals[2] = {3'b000, 29'($urandom)};
                vals[3] = $urandom_range(0, 32'h8000);
            end
            write_regions(vals);
            run_random(140);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
